// ===== hw/rtl/hjsc_pkg.sv =====
package hjsc_pkg;

    localparam logic [15:0] SYL_BASE = 16'hAC00;
    localparam logic [15:0] CONS_LO  = 16'h3131;
    localparam logic [15:0] CONS_HI  = 16'h314E;
    localparam logic [15:0] VOW_LO   = 16'h314F;
    localparam logic [15:0] VOW_HI   = 16'h3163;
    localparam logic [4:0]  NO_INI   = 5'd19;
    localparam logic [4:0]  NO_MED   = 5'd21;
    localparam logic [4:0]  NO_FIN   = 5'd0;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_CONS  = 2'd1,
        KIND_VOW   = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_EMPTY = 4'b0001,
        PH_INIT  = 4'b0010,
        PH_MED   = 4'b0100,
        PH_FIN   = 4'b1000
    } phase_t;

    // classified keystroke; off = consonant offset from CONS_LO
    typedef struct packed {
        logic [15:0] code;
        kind_t       kind;
        logic [4:0]  off;
        logic [4:0]  med;
        logic [4:0]  ini;
        logic [4:0]  fin;
    } item_t;

    typedef struct packed {
        logic [15:0] code;
        logic        rep;
        logic        last;
    } res_t;

    typedef struct packed {
        logic v0;
        logic v1;
        res_t r0;
        res_t r1;
    } oq_push_t;

    typedef struct packed {
        logic [4:0] keep_fin;
        logic [4:0] move_off;
    } split_t;

    // consonant offset -> initial index (NO_INI when not an initial)
    function automatic logic [4:0] ini_of_off(input logic [4:0] o);
        logic [4:0] r;
        unique case (o)
            5'd0:    r = 5'd0;
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd2;
            5'd6:    r = 5'd3;
            5'd7:    r = 5'd4;
            5'd8:    r = 5'd5;
            5'd16:   r = 5'd6;
            5'd17:   r = 5'd7;
            5'd18:   r = 5'd8;
            5'd20:   r = 5'd9;
            5'd21:   r = 5'd10;
            5'd22:   r = 5'd11;
            5'd23:   r = 5'd12;
            5'd24:   r = 5'd13;
            5'd25:   r = 5'd14;
            5'd26:   r = 5'd15;
            5'd27:   r = 5'd16;
            5'd28:   r = 5'd17;
            5'd29:   r = 5'd18;
            default: r = NO_INI;
        endcase
        return r;
    endfunction

    // consonant offset -> final index (NO_FIN when no final form)
    function automatic logic [4:0] fin_of_off(input logic [4:0] o);
        logic [4:0] r;
        priority if (o <= 5'd6)
            r = 5'(o + 5'd1);
        else if (o == 5'd7 || o == 5'd18 || o == 5'd24 || o >= 5'd30)
            r = NO_FIN;
        else if (o <= 5'd17)
            r = o;
        else if (o <= 5'd23)
            r = 5'(o - 5'd1);
        else
            r = 5'(o - 5'd2);
        return r;
    endfunction

    // final index (nonzero) -> consonant offset
    function automatic logic [4:0] off_of_fin(input logic [4:0] t);
        logic [4:0] r;
        priority if (t <= 5'd7)
            r = 5'(t - 5'd1);
        else if (t <= 5'd17)
            r = t;
        else if (t <= 5'd22)
            r = 5'(t + 5'd1);
        else
            r = 5'(t + 5'd2);
        return r;
    endfunction

    // two consonant offsets -> compound final index, NO_FIN if none
    function automatic logic [4:0] pair_fin(input logic [4:0] a, input logic [4:0] b);
        logic [4:0] r;
        r = NO_FIN;
        if (a == 5'd0 && b == 5'd20) r = 5'd3;
        if (a == 5'd3 && b == 5'd23) r = 5'd5;
        if (a == 5'd3 && b == 5'd29) r = 5'd6;
        if (a == 5'd8 && b == 5'd0)  r = 5'd9;
        if (a == 5'd8 && b == 5'd16) r = 5'd10;
        if (a == 5'd8 && b == 5'd17) r = 5'd11;
        if (a == 5'd8 && b == 5'd20) r = 5'd12;
        if (a == 5'd8 && b == 5'd27) r = 5'd13;
        if (a == 5'd8 && b == 5'd28) r = 5'd14;
        if (a == 5'd8 && b == 5'd29) r = 5'd15;
        if (a == 5'd17 && b == 5'd20) r = 5'd18;
        return r;
    endfunction

    // final index -> part that stays, consonant that moves on
    function automatic split_t split_fin(input logic [4:0] t);
        split_t s;
        s.keep_fin = NO_FIN;
        s.move_off = off_of_fin(t);
        unique case (t)
            5'd3:    begin s.keep_fin = 5'd1;  s.move_off = 5'd20; end
            5'd5:    begin s.keep_fin = 5'd4;  s.move_off = 5'd23; end
            5'd6:    begin s.keep_fin = 5'd4;  s.move_off = 5'd29; end
            5'd9:    begin s.keep_fin = 5'd8;  s.move_off = 5'd0;  end
            5'd10:   begin s.keep_fin = 5'd8;  s.move_off = 5'd16; end
            5'd11:   begin s.keep_fin = 5'd8;  s.move_off = 5'd17; end
            5'd12:   begin s.keep_fin = 5'd8;  s.move_off = 5'd20; end
            5'd13:   begin s.keep_fin = 5'd8;  s.move_off = 5'd27; end
            5'd14:   begin s.keep_fin = 5'd8;  s.move_off = 5'd28; end
            5'd15:   begin s.keep_fin = 5'd8;  s.move_off = 5'd29; end
            5'd18:   begin s.keep_fin = 5'd17; s.move_off = 5'd20; end
            default: ;
        endcase
        return s;
    endfunction

    // compound medials
    function automatic logic [4:0] med_combine(input logic [4:0] m1, input logic [4:0] m2);
        logic [4:0] r;
        r = NO_MED;
        if (m2 == 5'd20) begin
            if (m1 == 5'd0)  r = 5'd1;
            if (m1 == 5'd2)  r = 5'd3;
            if (m1 == 5'd4)  r = 5'd5;
            if (m1 == 5'd6)  r = 5'd7;
            if (m1 == 5'd8)  r = 5'd11;
            if (m1 == 5'd13) r = 5'd16;
            if (m1 == 5'd18) r = 5'd19;
        end
        else begin
            if (m1 == 5'd8 && m2 == 5'd0)  r = 5'd9;
            if (m1 == 5'd8 && m2 == 5'd1)  r = 5'd10;
            if (m1 == 5'd13 && m2 == 5'd4) r = 5'd14;
            if (m1 == 5'd13 && m2 == 5'd5) r = 5'd15;
        end
        return r;
    endfunction

    function automatic logic [15:0] make_syl(input logic [4:0] ini, input logic [4:0] med,
                                             input logic [4:0] fin);
        return 16'(SYL_BASE + 16'(ini) * 16'd588 + 16'(med) * 16'd28 + 16'(fin));
    endfunction

endpackage

// ===== hw/rtl/hangul_jamo_syllable_composer.sv =====
// Hangul two-set keyboard composer.
// Input channel (push/full): one 16-bit UTF-16 code unit per keystroke on
// char_code, taken at an edge with push high and full low.
// Result channel (empty/pop): each word is out_code, replace_previous (1 =
// overwrite the character being composed on screen) and last (1 on the final
// word caused by a keystroke). The head word is valid while empty is low and
// leaves at an edge with pop high.
// A front stage classifies keystrokes (consonant, vowel, other, table
// indices) into a 2-entry queue; the back stage holds the composing state
// and pushes one word, or two when a vowel pulls a final into a new syllable,
// into a 4-entry result queue.
// Throughput: one keystroke per cycle while words are popped; a keystroke that
// splits off a final gives two words on the result side, the only place that can slow it.
// Receiver stall: the result queue fills, the back stage waits for room for
// two words, the front queue fills and full rises; nothing is dropped.
// Reset clears both queues and returns composing to the empty phase.
module hangul_jamo_syllable_composer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] char_code,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] out_code,
    output logic        replace_previous,
    output logic        last
);
    import hjsc_pkg::*;

    logic     q_valid;
    item_t    q_item;
    logic     q_pop;
    logic     oq_room;
    oq_push_t oq_push;

    hjsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .char_code (char_code),
        .full      (full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    hjsc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .oq_room (oq_room),
        .oq_push (oq_push)
    );

    hjsc_outq u_outq (
        .clk              (clk),
        .rst_n            (rst_n),
        .oq_push          (oq_push),
        .oq_room          (oq_room),
        .empty            (empty),
        .pop              (pop),
        .out_code         (out_code),
        .replace_previous (replace_previous),
        .last             (last)
    );

endmodule

// ===== hw/rtl/hjsc_front.sv =====
module hjsc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [15:0]    char_code,
    output logic           full,
    output logic           q_valid,
    output hjsc_pkg::item_t q_item,
    input  logic           q_pop
);
    import hjsc_pkg::*;

    item_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    item_t       item_new;
    logic [15:0] cons_diff;
    logic [15:0] vow_diff;
    logic        push_ok;
    logic        pop_ok;

    // classify
    always_comb
    begin
        cons_diff      = 16'(char_code - CONS_LO);
        vow_diff       = 16'(char_code - VOW_LO);
        item_new.code  = char_code;
        item_new.off   = cons_diff[4:0];
        item_new.med   = vow_diff[4:0];
        item_new.ini   = ini_of_off(cons_diff[4:0]);
        item_new.fin   = fin_of_off(cons_diff[4:0]);
        priority if (char_code >= CONS_LO && char_code <= CONS_HI)
            item_new.kind = KIND_CONS;
        else if (char_code >= VOW_LO && char_code <= VOW_HI)
            item_new.kind = KIND_VOW;
        else
            item_new.kind = KIND_OTHER;
    end

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push_ok = push && !full;
    assign pop_ok  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push_ok ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_ok ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + {1'b0, push_ok} - {1'b0, pop_ok});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem_reg[wr_ptr_reg] <= item_new;
    end

    a_front_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("front queue count out of range");

endmodule

// ===== hw/rtl/hjsc_back.sv =====
module hjsc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  hjsc_pkg::item_t    q_item,
    output logic               q_pop,
    input  logic               oq_room,
    output hjsc_pkg::oq_push_t oq_push
);
    import hjsc_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [1:0] fcnt_reg, fcnt_next;
    logic [4:0] ini_reg, ini_next;
    logic [4:0] med_reg, med_next;
    logic [4:0] fin_reg, fin_next;
    logic [4:0] fj0_reg, fj0_next;
    logic [4:0] fj1_reg, fj1_next;

    logic       take;
    logic [4:0] comp_fin;
    logic [4:0] new_med;
    split_t     sp;
    logic [4:0] keep_fin;
    logic [4:0] move_ini;

    assign take  = q_valid && oq_room;
    assign q_pop = take;

    always_comb
    begin
        comp_fin = pair_fin(fj0_reg, q_item.off);
        new_med  = med_combine(med_reg, q_item.med);
        sp       = split_fin(fin_reg);
        if (fcnt_reg == 2'd2)
        begin
            keep_fin = fin_of_off(fj0_reg);
            move_ini = ini_of_off(fj1_reg);
        end
        else
        begin
            keep_fin = sp.keep_fin;
            move_ini = ini_of_off(sp.move_off);
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        fcnt_next  = fcnt_reg;
        ini_next   = ini_reg;
        med_next   = med_reg;
        fin_next   = fin_reg;
        fj0_next   = fj0_reg;
        fj1_next   = fj1_reg;

        // default: word appended alone, composing restarts
        oq_push.v0      = take;
        oq_push.v1      = 1'b0;
        oq_push.r0.code = q_item.code;
        oq_push.r0.rep  = 1'b0;
        oq_push.r0.last = 1'b1;
        oq_push.r1.code = make_syl(move_ini, q_item.med, NO_FIN);
        oq_push.r1.rep  = 1'b0;
        oq_push.r1.last = 1'b1;

        if (take)
        begin
            fcnt_next  = 2'd0;
            phase_next = PH_EMPTY;
            unique case (q_item.kind)
                KIND_CONS:
                begin
                    priority if (phase_reg == PH_MED && q_item.fin != NO_FIN)
                    begin
                        fj0_next        = q_item.off;
                        fcnt_next       = 2'd1;
                        fin_next        = q_item.fin;
                        phase_next      = PH_FIN;
                        oq_push.r0.code = make_syl(ini_reg, med_reg, q_item.fin);
                        oq_push.r0.rep  = 1'b1;
                    end
                    else if (phase_reg == PH_FIN && fcnt_reg == 2'd1 && comp_fin != NO_FIN)
                    begin
                        fj1_next        = q_item.off;
                        fcnt_next       = 2'd2;
                        fin_next        = comp_fin;
                        phase_next      = PH_FIN;
                        oq_push.r0.code = make_syl(ini_reg, med_reg, comp_fin);
                        oq_push.r0.rep  = 1'b1;
                    end
                    else
                    begin
                        // new syllable, consonant as its initial
                        ini_next   = q_item.ini;
                        phase_next = PH_INIT;
                    end
                end
                KIND_VOW:
                begin
                    unique case (phase_reg)
                        PH_INIT:
                        begin
                            if (ini_reg != NO_INI)
                            begin
                                med_next        = q_item.med;
                                fin_next        = NO_FIN;
                                phase_next      = PH_MED;
                                oq_push.r0.code = make_syl(ini_reg, q_item.med, NO_FIN);
                                oq_push.r0.rep  = 1'b1;
                            end
                        end
                        PH_MED:
                        begin
                            if (new_med != NO_MED)
                            begin
                                med_next        = new_med;
                                phase_next      = PH_MED;
                                oq_push.r0.code = make_syl(ini_reg, new_med, NO_FIN);
                                oq_push.r0.rep  = 1'b1;
                            end
                        end
                        PH_FIN:
                        begin
                            // final (or its second half) moves to a new syllable
                            if (move_ini != NO_INI)
                            begin
                                oq_push.v1      = 1'b1;
                                oq_push.r0.code = make_syl(ini_reg, med_reg, keep_fin);
                                oq_push.r0.rep  = 1'b1;
                                oq_push.r0.last = 1'b0;
                                ini_next        = move_ini;
                                med_next        = q_item.med;
                                fin_next        = NO_FIN;
                                phase_next      = PH_MED;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_EMPTY;
            fcnt_reg  <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            fcnt_reg  <= fcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ini_reg <= ini_next;
        med_reg <= med_next;
        fin_reg <= fin_next;
        fj0_reg <= fj0_next;
        fj1_reg <= fj1_next;
    end

    a_fin_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FIN) |-> (fcnt_reg == 2'd1 || fcnt_reg == 2'd2))
        else $error("final phase without final consonant");

    a_no_fin_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_FIN) |-> (fcnt_reg == 2'd0))
        else $error("final count set outside final phase");

    a_split_needs_final: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push.v1 |-> (take && phase_reg == PH_FIN && $past(phase_next) != PH_EMPTY
                        || take && phase_reg == PH_FIN))
        else $error("two words pushed outside a final split");

endmodule

// ===== hw/rtl/hjsc_outq.sv =====
module hjsc_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  hjsc_pkg::oq_push_t oq_push,
    output logic               oq_room,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        out_code,
    output logic               replace_previous,
    output logic               last
);
    import hjsc_pkg::*;

    res_t       mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop_ok;
    res_t       head;

    assign empty            = (count_reg == 3'd0);
    assign oq_room          = (count_reg <= 3'd2);
    assign pop_ok           = pop && !empty;
    assign head             = mem_reg[rd_ptr_reg];
    assign out_code         = head.code;
    assign replace_previous = head.rep;
    assign last             = head.last;

    always_comb
    begin
        wr_ptr_next = 2'(wr_ptr_reg + {1'b0, oq_push.v0} + {1'b0, oq_push.v1});
        rd_ptr_next = 2'(rd_ptr_reg + {1'b0, pop_ok});
        count_next  = 3'(count_reg + {2'b0, oq_push.v0} + {2'b0, oq_push.v1}
                         - {2'b0, pop_ok});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push.v0)
            mem_reg[wr_ptr_reg] <= oq_push.r0;
        if (oq_push.v1)
            mem_reg[2'(wr_ptr_reg + 2'd1)] <= oq_push.r1;
    end

    a_oq_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push.v0 |-> oq_room)
        else $error("word pushed without room for a split");

endmodule
